[design/cascaded_motor_pid_controller_unit_assert.svh]
// assertion macros for the cascaded motor pid controller
`ifndef CASCADED_MOTOR_PID_CONTROLLER_UNIT_ASSERT_SVH
`define CASCADED_MOTOR_PID_CONTROLLER_UNIT_ASSERT_SVH
// implication checked on every clock edge outside reset
`define CMPC_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
// implication checked in the cycle after the antecedent
`define CMPC_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

[design/cmpc_pkg.sv]
// shared constants, types and helpers of the motor pid controller
package cmpc_pkg;
    localparam int VelocityOutLimit = 10000;
    localparam int PositionOutLimit = 8000;
    localparam int PeriodQ16 = 66;

    localparam int CfgIdxW = 3;
    localparam int CfgDataW = 48;
    localparam logic [CfgIdxW-1:0] REG_MODE = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_MOTOR = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_TPOS = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_TVEL = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_VGAIN = 3'd4;
    localparam logic [CfgIdxW-1:0] REG_PGAIN = 3'd5;

    localparam logic [1:0] MODE_NONE = 2'd0;
    localparam logic [1:0] MODE_POSITION = 2'd1;
    localparam logic [1:0] MODE_VELOCITY = 2'd2;
    localparam logic [1:0] MODE_SPARE = 2'd3;

    localparam logic signed [13:0] WRAP_COUNTS = 14'sd8191;
    localparam logic [22:0] SCALE_R19 = 23'd7060022;
    localparam logic [22:0] SCALE_R36 = 23'd3726123;
    localparam logic signed [127:0] VEL_P_CLAMP = 128'sd9500;
    localparam logic signed [127:0] POS_P_CLAMP = 128'sd503316480000;
    localparam logic signed [127:0] D_CLAMP = 128'sd72057594037927936;
    localparam logic signed [127:0] S48_MAX = 128'sd140737488355327;
    localparam logic signed [127:0] S48_MIN = -128'sd140737488355328;
    localparam logic signed [127:0] DECAY_Q16 = 128'sd64881;

    // datapath operations
    typedef enum logic [3:0] {
        OP_NONE, OP_UNWRAP, OP_SCALE, OP_PERR, OP_PTERMS, OP_PSUM, OP_PINT,
        OP_VERR, OP_VTERMS, OP_VSUM, OP_VINT, OP_ZERO
    } cmpc_op_t;

    typedef struct packed {
        cmpc_op_t op;
        logic     load_in;
    } cmpc_cmd_t;

    typedef struct packed {
        logic [1:0] mode;
    } cmpc_stat_t;

    function automatic logic signed [127:0] clamp128(
        input logic signed [127:0] x, input logic signed [127:0] lim_lo,
        input logic signed [127:0] lim_hi);
        clamp128 = (x < lim_lo) ? lim_lo : ((x > lim_hi) ? lim_hi : x);
    endfunction

    function automatic logic signed [127:0] trunc_shr(
        input logic signed [127:0] x, input int unsigned s);
        logic signed [127:0] a;
        a = (x < 0) ? -x : x;
        a = a >>> s;
        trunc_shr = (x < 0) ? -a : a;
    endfunction
endpackage

[design/cascaded_motor_pid_controller_unit.sv]
// top level of the cascaded position and velocity pid controller
//  channel  | direction | handshake          | payload
//  s_       | in        | s_valid / s_ready  | encoder_angle, rotor_speed
//  m_       | out       | m_valid / m_ready  | target_current, velocity_command,
//           |           |                    | shaft_position
//  cfg_     | in        | cfg_we             | cfg_index, cfg_data
// one sample unwraps and scales the angle; velocity mode adds the velocity loop,
// position mode both; the sequencer steps the shared datapath one operation a cycle
// the result beat is held in the output register; a new sample is taken once
// it has been taken. synchronous active-low reset clears all loop state
module cascaded_motor_pid_controller_unit #(
    parameter int VELOCITY_OUT_LIMIT = cmpc_pkg::VelocityOutLimit,
    parameter int POSITION_OUT_LIMIT = cmpc_pkg::PositionOutLimit,
    parameter int PERIOD_Q16 = cmpc_pkg::PeriodQ16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [12:0]                   s_encoder_angle,
    input  logic signed [15:0]            s_rotor_speed,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [15:0]            m_target_current,
    output logic signed [15:0]            m_velocity_command,
    output logic signed [47:0]            m_shaft_position,
    input  logic                          cfg_we,
    input  logic [cmpc_pkg::CfgIdxW-1:0]  cfg_index,
    input  logic [cmpc_pkg::CfgDataW-1:0] cfg_data
);
    import cmpc_pkg::*;

    logic [1:0] mode_reg;
    logic motor_reg;
    logic signed [47:0] tpos_reg;
    logic signed [15:0] tvel_reg;
    logic [47:0] vgain_reg, pgain_reg;
    cmpc_cmd_t cmd;
    cmpc_stat_t stat;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= '0;
            motor_reg <= 1'b0;
            tpos_reg <= '0;
            tvel_reg <= '0;
            vgain_reg <= '0;
            pgain_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_MODE:  mode_reg <= cfg_data[1:0];
                REG_MOTOR: motor_reg <= cfg_data[0];
                REG_TPOS:  tpos_reg <= cfg_data;
                REG_TVEL:  tvel_reg <= cfg_data[15:0];
                REG_VGAIN: vgain_reg <= cfg_data;
                REG_PGAIN: pgain_reg <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign stat.mode = mode_reg;

    cmpc_control u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_valid), .in_ready(s_ready),
        .out_valid(m_valid), .out_ready(m_ready),
        .stat(stat), .cmd(cmd)
    );

    cmpc_datapath #(
        .VEL_LIMIT(VELOCITY_OUT_LIMIT), .POS_LIMIT(POSITION_OUT_LIMIT), .PERIOD(PERIOD_Q16)
    ) u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd),
        .in_angle(s_encoder_angle), .in_speed(s_rotor_speed),
        .cfg_motor(motor_reg), .cfg_tpos(tpos_reg),
        .cfg_tvel(tvel_reg), .cfg_vgain(vgain_reg), .cfg_pgain(pgain_reg),
        .res_current(m_target_current), .res_vcmd(m_velocity_command),
        .res_shaft(m_shaft_position)
    );
endmodule

[design/cmpc_datapath.sv]
// pid datapath: angle unwrap, position scaling and the two control loops
module cmpc_datapath #(
    parameter int VEL_LIMIT = cmpc_pkg::VelocityOutLimit,
    parameter int POS_LIMIT = cmpc_pkg::PositionOutLimit,
    parameter int PERIOD = cmpc_pkg::PeriodQ16
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  cmpc_pkg::cmpc_cmd_t      cmd,
    input  logic [12:0]              in_angle,
    input  logic signed [15:0]       in_speed,
    input  logic                     cfg_motor,
    input  logic signed [47:0]       cfg_tpos,
    input  logic signed [15:0]       cfg_tvel,
    input  logic [47:0]              cfg_vgain,
    input  logic [47:0]              cfg_pgain,
    output logic signed [15:0]       res_current,
    output logic signed [15:0]       res_vcmd,
    output logic signed [47:0]       res_shaft
);
    import cmpc_pkg::*;

    logic [12:0] prev_angle_reg;
    logic [31:0] count_reg;
    logic signed [17:0] vlast_reg;
    logic signed [47:0] vint_reg, plast_reg, pint_reg;
    logic [12:0] angle_reg;
    logic signed [15:0] speed_reg;
    logic signed [47:0] shaft_reg, perr_reg;
    logic signed [17:0] verr_reg;
    logic signed [63:0] pterm_reg, dterm_reg;
    logic signed [15:0] vcmd_reg, cur_reg;
    logic psat_reg, vsat_reg;

    logic signed [13:0] d1, d2, a1, a2, dsel;
    logic signed [127:0] t_a, t_b, t_c, t_sum;
    logic signed [127:0] vlim, plim;

    assign vlim = 128'(VEL_LIMIT);
    assign plim = 128'(POS_LIMIT);

    always_comb begin
        d2 = $signed({1'b0, angle_reg}) - $signed({1'b0, prev_angle_reg});
        d1 = (angle_reg < prev_angle_reg) ? d2 + WRAP_COUNTS : d2 - WRAP_COUNTS;
        a1 = (d1 < 0) ? -d1 : d1;
        a2 = (d2 < 0) ? -d2 : d2;
        dsel = (a1 < a2) ? d1 : d2;
    end

    always_comb begin
        t_a = '0;
        t_b = '0;
        t_c = '0;
        t_sum = '0;
        unique case (cmd.op)
            OP_SCALE: begin
                t_a = 128'($signed(count_reg)) * $signed({1'b0, cfg_motor ? SCALE_R36 : SCALE_R19});
                t_sum = (t_a + 128'sd32768) >>> 16;
            end
            OP_PERR: begin
                t_sum = clamp128(128'(cfg_tpos) - 128'(shaft_reg), S48_MIN, S48_MAX);
            end
            OP_PTERMS: begin
                t_a = clamp128(128'(perr_reg) * $signed({1'b0, cfg_pgain[15:0]}),
                    -POS_P_CLAMP, POS_P_CLAMP);
                t_b = clamp128(128'(perr_reg) - 128'(plast_reg), S48_MIN, S48_MAX);
                t_c = clamp128(t_b * $signed({1'b0, cfg_pgain[47:32]}), -D_CLAMP, D_CLAMP);
            end
            OP_PSUM: begin
                t_sum = clamp128(trunc_shr(128'(pterm_reg) + 128'(dterm_reg)
                    + (128'(pint_reg) <<< 8), 24), -plim, plim);
            end
            OP_PINT: begin
                t_a = (128'(perr_reg) * $signed({1'b0, cfg_pgain[31:16]})) >>> 16;
                t_b = (t_a * 128'(PERIOD)) >>> 8;
            end
            OP_VERR: begin
                t_sum = 128'(vcmd_reg) - 128'(speed_reg);
            end
            OP_VTERMS: begin
                t_a = clamp128(128'(verr_reg) * $signed({1'b0, cfg_vgain[15:0]}),
                    -VEL_P_CLAMP, VEL_P_CLAMP);
                t_c = (128'(verr_reg) - 128'(vlast_reg)) * $signed({1'b0, cfg_vgain[47:32]});
            end
            OP_VSUM: begin
                t_sum = clamp128(trunc_shr(((128'(pterm_reg) + 128'(dterm_reg)) <<< 16)
                    + 128'(vint_reg), 16), -vlim, vlim);
            end
            OP_VINT: begin
                t_b = 128'(PERIOD) * 128'(verr_reg) * $signed({1'b0, cfg_vgain[31:16]});
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_angle_reg <= '0;
            count_reg <= '0;
            vlast_reg <= '0;
            vint_reg <= '0;
            plast_reg <= '0;
            pint_reg <= '0;
        end else begin
            if (cmd.load_in) begin
                angle_reg <= in_angle;
                speed_reg <= in_speed;
            end
            unique case (cmd.op)
                OP_UNWRAP: begin
                    prev_angle_reg <= angle_reg;
                    count_reg <= count_reg + 32'(dsel);
                    vcmd_reg <= '0;
                    cur_reg <= '0;
                end
                OP_SCALE: shaft_reg <= t_sum[47:0];
                OP_PERR: perr_reg <= t_sum[47:0];
                OP_PTERMS: begin
                    pterm_reg <= t_a[63:0];
                    dterm_reg <= t_c[63:0];
                    plast_reg <= perr_reg;
                end
                OP_PSUM: begin
                    vcmd_reg <= t_sum[15:0];
                    psat_reg <= (t_sum == plim) || (t_sum == -plim);
                end
                OP_PINT: begin
                    if (psat_reg) pint_reg <= 48'(trunc_shr(128'(pint_reg) * DECAY_Q16, 16));
                    else pint_reg <= 48'(clamp128(128'(pint_reg) + t_b, S48_MIN, S48_MAX));
                end
                OP_VERR: verr_reg <= t_sum[17:0];
                OP_VTERMS: begin
                    pterm_reg <= t_a[63:0];
                    dterm_reg <= t_c[63:0];
                    vlast_reg <= verr_reg;
                end
                OP_VSUM: begin
                    cur_reg <= t_sum[15:0];
                    vsat_reg <= (t_sum == vlim) || (t_sum == -vlim);
                end
                OP_VINT: begin
                    if (vsat_reg) vint_reg <= 48'(trunc_shr(128'(vint_reg) * DECAY_Q16, 16));
                    else vint_reg <= 48'(clamp128(128'(vint_reg) + t_b, S48_MIN, S48_MAX));
                end
                OP_ZERO: vcmd_reg <= cfg_tvel;
                default: begin
                end
            endcase
        end
    end

    assign res_current = cur_reg;
    assign res_vcmd = vcmd_reg;
    assign res_shaft = shaft_reg;
endmodule

[design/cmpc_control.sv]
// sequencer that steps the datapath through one feedback sample
module cmpc_control (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  logic                  out_ready,
    input  cmpc_pkg::cmpc_stat_t  stat,
    output cmpc_pkg::cmpc_cmd_t   cmd
);
    import cmpc_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE, ST_UNWRAP, ST_SCALE, ST_PERR, ST_PTERMS, ST_PSUM, ST_PINT,
        ST_VSET, ST_VERR, ST_VTERMS, ST_VSUM, ST_VINT, ST_DONE
    } state_t;

    state_t state_reg;
    logic out_valid_reg;

    always_comb begin
        cmd.load_in = (state_reg == ST_IDLE) && in_valid;
        unique case (state_reg)
            ST_UNWRAP: cmd.op = OP_UNWRAP;
            ST_SCALE:  cmd.op = OP_SCALE;
            ST_PERR:   cmd.op = OP_PERR;
            ST_PTERMS: cmd.op = OP_PTERMS;
            ST_PSUM:   cmd.op = OP_PSUM;
            ST_PINT:   cmd.op = OP_PINT;
            ST_VSET:   cmd.op = OP_ZERO;
            ST_VERR:   cmd.op = OP_VERR;
            ST_VTERMS: cmd.op = OP_VTERMS;
            ST_VSUM:   cmd.op = OP_VSUM;
            ST_VINT:   cmd.op = OP_VINT;
            default:   cmd.op = OP_NONE;
        endcase
    end

    // result beat held until taken; next sample waits for it
    assign in_ready = (state_reg == ST_IDLE) && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            if (out_valid_reg && out_ready) out_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE: if (in_valid && in_ready) state_reg <= ST_UNWRAP;
                ST_UNWRAP: state_reg <= ST_SCALE;
                ST_SCALE: begin
                    if (stat.mode == MODE_POSITION) state_reg <= ST_PERR;
                    else if (stat.mode == MODE_VELOCITY) state_reg <= ST_VSET;
                    else state_reg <= ST_DONE;
                end
                ST_PERR: state_reg <= ST_PTERMS;
                ST_PTERMS: state_reg <= ST_PSUM;
                ST_PSUM: state_reg <= ST_PINT;
                ST_PINT: state_reg <= ST_VERR;
                ST_VSET: state_reg <= ST_VERR;
                ST_VERR: state_reg <= ST_VTERMS;
                ST_VTERMS: state_reg <= ST_VSUM;
                ST_VSUM: state_reg <= ST_VINT;
                ST_VINT: state_reg <= ST_DONE;
                ST_DONE: begin
                    out_valid_reg <= 1'b1;
                    state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end
endmodule

[design/cmpc_checker.sv]
// port-level checker for the motor pid controller, bound to the top level
`include "cascaded_motor_pid_controller_unit_assert.svh"
module cmpc_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input logic signed [15:0] m_target_current,
    input logic signed [15:0] m_velocity_command
);
    `CMPC_ASSERT_IMP(a_cur_range, aclk, aresetn, m_valid,
        (m_target_current <= 16'sd16384) && (m_target_current >= -16'sd16384))
    `CMPC_ASSERT_NEXT(a_no_back2back, aclk, aresetn, s_valid && s_ready, !s_ready)
    `CMPC_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready,
        m_valid && $stable(m_velocity_command))
endmodule

bind cascaded_motor_pid_controller_unit cmpc_checker u_chk (
    .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
    .m_valid(m_valid), .m_ready(m_ready), .m_target_current(m_target_current),
    .m_velocity_command(m_velocity_command)
);
